>>> rtl/assert_macros.svh
// Assertion macros for the RTL files that carry concurrent checks.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, disabled while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/ps2dec_pkg.sv
// Package for the PS/2 set 1 decoder: sizes, scancode constants, key ROMs,
// shared structs and small helper functions. Depends on nothing.
package ps2dec_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    // Result queue in front of the output channel (power of two).
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    typedef logic [PTR_W-1:0] t_ptr;

    // Scancode constants
    localparam logic [7:0] SC_PREFIX_E0 = 8'hE0;
    localparam logic [6:0] SC_LSHIFT    = 7'h2A;
    localparam logic [6:0] SC_RSHIFT    = 7'h36;
    localparam logic [6:0] SC_CTRL      = 7'h1D;
    localparam logic [6:0] SC_ALT       = 7'h38;
    localparam logic [6:0] SC_CAPS      = 7'h3A;
    localparam logic [6:0] SC_NUM       = 7'h45;
    localparam logic [6:0] SC_SCROLL    = 7'h46;

    // Command byte that sets the keyboard LEDs
    localparam logic [7:0] KBD_CMD_LED = 8'hED;

    // Modifier bit positions
    localparam int MOD_SHIFT  = 0;
    localparam int MOD_CTRL   = 1;
    localparam int MOD_ALT    = 2;
    localparam int MOD_CAPS   = 3;
    localparam int MOD_NUM    = 4;
    localparam int MOD_SCROLL = 5;

    // Result kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    // US QWERTY, no modifier
    localparam logic [7:0] ROM_PLAIN [0:127] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84,
        8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h8A,
        8'h8B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // US QWERTY with shift held; function keys and keypad keys other than * have no entry
    localparam logic [7:0] ROM_SHIFT [0:127] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // One result transaction
    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       fifo_empty;
        logic [5:0] modifier_bits;
        logic       last;
    } t_result;

    // Up to two results landing in the output queue in one cycle
    typedef struct packed {
        logic    valid;
        logic    two;
        t_result res0;
        t_result res1;
    } t_qpush;

    // Outcome of decoding one scancode byte
    typedef struct packed {
        logic       ext;
        logic [5:0] mods;
        logic       push;
        logic [7:0] ch;
        logic       caps_evt;
        logic [7:0] leds;
    } t_xlate;

    // Advance a character FIFO pointer with wrap at FIFO_DEPTH
    function automatic t_ptr ptr_inc(input t_ptr p);
        t_ptr r;
        if (p == t_ptr'(FIFO_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + t_ptr'(1);
        end
        return r;
    endfunction

    // Cursor and navigation keys behind the E0 prefix
    function automatic logic [7:0] ext_code(input logic [6:0] sc);
        logic [7:0] r;
        unique case (sc)
            7'h48:   r = 8'h90;
            7'h50:   r = 8'h91;
            7'h4B:   r = 8'h92;
            7'h4D:   r = 8'h93;
            7'h47:   r = 8'h94;
            7'h4F:   r = 8'h95;
            7'h49:   r = 8'h96;
            7'h51:   r = 8'h97;
            7'h52:   r = 8'h98;
            7'h53:   r = 8'h99;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/ps2dec_if.sv
// Valid/ready channel interfaces for the decoder's input and result streams.
// Depends on nothing.
interface ps2dec_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] scan_byte;

    modport source (output valid, output func, output scan_byte, input ready);
    modport sink   (input valid, input func, input scan_byte, output ready);
endinterface

interface ps2dec_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] value;
    logic       fifo_empty;
    logic [5:0] modifier_bits;
    logic       last;

    modport source (output valid, output kind, output value, output fifo_empty,
                    output modifier_bits, output last, input ready);
    modport sink   (input valid, input kind, input value, input fifo_empty,
                    input modifier_bits, input last, output ready);
endinterface

>>> rtl/ps2_set1_scancode_decoder.sv
// PS/2 scancode set 1 decoder with a character FIFO held in block memory.
// Channels: i_in (sink) takes one transaction per item: func=0 delivers a raw
// set 1 byte in scan_byte, func=1 asks for one character from the FIFO.
// o_out (source) returns result transactions: a read gives one character
// (0 when the FIFO is empty); a caps lock press gives the LED command 0xED
// and then the LED byte, the second one flagged by last. Every other byte
// gives no result. Each result also reports fifo_empty and the modifiers.
// Throughput: one input transaction per cycle while i_in.ready is high.
// A result passes the staging register and the store read data, then the
// result queue registers, before it shows on o_out. The store is a
// synchronous RAM with one port use per cycle (a read or a push, never
// both, since each item is one or the other); the FIFO pointers and
// modifiers sit in flip-flops. A caps lock press gives two results, which
// leave the queue one at a time, so a stream of them runs below full rate.
// Reset (i_rst_n low at a clock edge) clears the pointers, the modifiers,
// the E0 prefix flag, the pipeline and the result queue; the store is not
// cleared. When the receiver stalls, results collect in a four-entry queue
// and i_in.ready drops once a further item might not find room.
`include "assert_macros.svh"

module ps2_set1_scancode_decoder import ps2dec_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ps2dec_in_if.sink     i_in,
    ps2dec_out_if.source  o_out
);

    // Item that has results, held in a register while the store read data comes back
    typedef struct packed {
        logic       valid;
        logic       is_read;
        logic       hit;
        logic       fifo_empty;
        logic [5:0] mods;
        logic [7:0] leds;
    } t_s1;

    logic [7:0]       r_store [FIFO_DEPTH];
    logic [7:0]       r_rdata;
    t_ptr             r_rd;
    t_ptr             r_wr;
    logic [5:0]       r_mods;
    logic             r_ext;
    t_s1              r_s1;

    t_ptr             n_rd;
    t_ptr             n_wr;
    logic [5:0]       n_mods;
    logic             n_ext;
    t_s1              n_s1;

    t_xlate           w_xl;
    t_qpush           w_push;
    logic [CNT_W-1:0] w_qcnt;
    logic [CNT_W:0]   w_need;
    logic             w_acc;
    logic             w_empty;
    logic             w_full;
    logic             w_mem_rd;
    logic             w_mem_wr;

    ps2dec_xlate u_xlate (
        .i_scan_byte   (i_in.scan_byte),
        .i_ext_pending (r_ext),
        .i_mods        (r_mods),
        .o_xl          (w_xl)
    );

    // Accept only while the queue can absorb the item in flight plus a
    // worst-case new one (two results).
    always_comb begin
        w_need = {1'b0, w_qcnt} + (CNT_W+1)'(2);
        if (r_s1.valid) begin
            w_need = w_need + (r_s1.is_read ? (CNT_W+1)'(1) : (CNT_W+1)'(2));
        end
    end
    assign i_in.ready = (w_need <= (CNT_W+1)'(QDEPTH));
    assign w_acc      = i_in.valid && i_in.ready;

    assign w_empty  = (r_rd == r_wr);
    assign w_full   = (ptr_inc(r_wr) == r_rd);
    assign w_mem_rd = w_acc && i_in.func && !w_empty;
    assign w_mem_wr = w_acc && !i_in.func && w_xl.push && !w_full;

    always_comb begin
        n_rd   = w_mem_rd ? ptr_inc(r_rd) : r_rd;
        n_wr   = w_mem_wr ? ptr_inc(r_wr) : r_wr;
        n_mods = r_mods;
        n_ext  = r_ext;
        if (w_acc && !i_in.func) begin
            n_mods = w_xl.mods;
            n_ext  = w_xl.ext;
        end
        n_s1            = '0;
        n_s1.valid      = w_acc && (i_in.func || w_xl.caps_evt);
        n_s1.is_read    = i_in.func;
        n_s1.hit        = !w_empty;
        n_s1.fifo_empty = (n_rd == n_wr);
        n_s1.mods       = n_mods;
        n_s1.leds       = w_xl.leds;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd   <= '0;
            r_wr   <= '0;
            r_mods <= '0;
            r_ext  <= 1'b0;
            r_s1   <= '0;
        end else begin
            r_rd   <= n_rd;
            r_wr   <= n_wr;
            r_mods <= n_mods;
            r_ext  <= n_ext;
            r_s1   <= n_s1;
        end
    end

    // Character store: write on push, registered read on pop
    always_ff @(posedge i_clk) begin
        if (w_mem_wr) r_store[r_wr] <= w_xl.ch;
        if (w_mem_rd) r_rdata <= r_store[r_rd];
    end

    // Form the result transactions once the read data is back
    always_comb begin
        w_push       = '0;
        w_push.valid = r_s1.valid;
        w_push.two   = !r_s1.is_read;
        w_push.res0.fifo_empty    = r_s1.fifo_empty;
        w_push.res0.modifier_bits = r_s1.mods;
        w_push.res1.fifo_empty    = r_s1.fifo_empty;
        w_push.res1.modifier_bits = r_s1.mods;
        w_push.res1.kind          = KIND_CMD;
        w_push.res1.value         = r_s1.leds;
        w_push.res1.last          = 1'b1;
        if (r_s1.is_read) begin
            w_push.res0.kind  = KIND_CHAR;
            w_push.res0.value = r_s1.hit ? r_rdata : 8'h00;
            w_push.res0.last  = 1'b1;
        end else begin
            w_push.res0.kind  = KIND_CMD;
            w_push.res0.value = KBD_CMD_LED;
            w_push.res0.last  = 1'b0;
        end
    end

    ps2dec_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_cnt   (w_qcnt),
        .o_out   (o_out)
    );

    // The store port serves one access per cycle
    `ASSERT_NEVER(a_store_one_access, i_clk, i_rst_n, w_mem_rd && w_mem_wr, "store read and write collide")
    // Queue never overflows
    `ASSERT_NEVER(a_queue_bound, i_clk, i_rst_n, w_qcnt > CNT_W'(QDEPTH), "result queue overflow")
    // A staged item always lands in the queue
    `ASSERT_CLK(a_stage_lands, i_clk, i_rst_n, r_s1.valid |=> o_out.valid, "staged result lost")
    // Reading an empty FIFO leaves the read pointer alone
    `ASSERT_CLK(a_empty_read_hold, i_clk, i_rst_n, (w_acc && i_in.func && w_empty) |=> $stable(r_rd), "empty read moved pointer")

endmodule

>>> rtl/ps2dec_xlate.sv
// Scancode translation: prefix and modifier tracking, ROM lookup, case and
// ctrl mapping. Purely combinational. Depends on ps2dec_pkg.
module ps2dec_xlate import ps2dec_pkg::*; (
    input  logic [7:0] i_scan_byte,
    input  logic       i_ext_pending,
    input  logic [5:0] i_mods,
    output t_xlate     o_xl
);

    logic [6:0] w_sc;
    logic       w_rel;
    logic       w_shift;
    logic       w_caps;
    logic [7:0] w_rom;
    logic [7:0] w_cased;
    logic [7:0] w_ch;

    assign w_sc    = i_scan_byte[6:0];
    assign w_rel   = i_scan_byte[7];
    assign w_shift = i_mods[MOD_SHIFT];
    assign w_caps  = i_mods[MOD_CAPS];
    assign w_rom   = w_shift ? ROM_SHIFT[w_sc] : ROM_PLAIN[w_sc];

    // Caps lock inverts letter case; ctrl folds letters onto 1..26
    always_comb begin
        w_cased = w_rom;
        if (w_caps && w_rom >= 8'h61 && w_rom <= 8'h7A) begin
            w_cased = w_rom - 8'h20;
        end else if (w_caps && w_shift && w_rom >= 8'h41 && w_rom <= 8'h5A) begin
            w_cased = w_rom + 8'h20;
        end
        w_ch = w_cased;
        if (i_mods[MOD_CTRL]) begin
            if (w_cased >= 8'h61 && w_cased <= 8'h7A) begin
                w_ch = w_cased - 8'h60;
            end else if (w_cased >= 8'h41 && w_cased <= 8'h5A) begin
                w_ch = w_cased - 8'h40;
            end
        end
    end

    always_comb begin
        o_xl          = '0;
        o_xl.ext      = i_ext_pending;
        o_xl.mods     = i_mods;
        if (i_scan_byte == SC_PREFIX_E0) begin
            o_xl.ext = 1'b1;
        end else if (i_ext_pending) begin
            o_xl.ext = 1'b0;
            if (!w_rel) begin
                o_xl.ch   = ext_code(w_sc);
                o_xl.push = (o_xl.ch != 8'h00);
            end
        end else begin
            unique case (w_sc)
                SC_LSHIFT, SC_RSHIFT: o_xl.mods[MOD_SHIFT] = !w_rel;
                SC_CTRL:              o_xl.mods[MOD_CTRL]  = !w_rel;
                SC_ALT:               o_xl.mods[MOD_ALT]   = !w_rel;
                SC_CAPS: begin
                    if (!w_rel) begin
                        o_xl.mods[MOD_CAPS] = !i_mods[MOD_CAPS];
                        o_xl.caps_evt       = 1'b1;
                    end
                end
                SC_NUM: begin
                    if (!w_rel) o_xl.mods[MOD_NUM] = !i_mods[MOD_NUM];
                end
                SC_SCROLL: begin
                    if (!w_rel) o_xl.mods[MOD_SCROLL] = !i_mods[MOD_SCROLL];
                end
                default: begin
                    if (!w_rel) begin
                        o_xl.ch   = w_ch;
                        o_xl.push = (w_ch != 8'h00);
                    end
                end
            endcase
        end
        // LED byte: scroll in bit 0, num in bit 1, caps in bit 2
        o_xl.leds = {5'b0, o_xl.mods[MOD_CAPS], o_xl.mods[MOD_NUM],
                     o_xl.mods[MOD_SCROLL]};
    end

endmodule

>>> rtl/ps2dec_outq.sv
// Small result queue that drives the output channel from registers and
// takes up to two results per cycle. Depends on ps2dec_pkg, ps2dec_if.
module ps2dec_outq import ps2dec_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_qpush             i_push,
    output logic [CNT_W-1:0]   o_cnt,
    ps2dec_out_if.source       o_out
);

    t_result                r_q [QDEPTH];
    logic [QPTR_W-1:0]      r_head;
    logic [QPTR_W-1:0]      r_tail;
    logic [CNT_W-1:0]       r_cnt;
    logic [QPTR_W-1:0]      n_head;
    logic [QPTR_W-1:0]      n_tail;
    logic [CNT_W-1:0]       n_cnt;
    logic                   w_pop;
    logic [CNT_W-1:0]       w_npush;

    assign w_pop   = o_out.valid && o_out.ready;
    assign w_npush = !i_push.valid ? CNT_W'(0) : (i_push.two ? CNT_W'(2) : CNT_W'(1));

    always_comb begin
        n_head = w_pop ? r_head + QPTR_W'(1) : r_head;
        n_tail = r_tail + QPTR_W'(w_npush);
        n_cnt  = r_cnt + w_npush - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
        end
    end

    // Payload slots need no reset
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_q[r_tail] <= i_push.res0;
            if (i_push.two) r_q[r_tail + QPTR_W'(1)] <= i_push.res1;
        end
    end

    assign o_cnt               = r_cnt;
    assign o_out.valid         = (r_cnt != '0);
    assign o_out.kind          = r_q[r_head].kind;
    assign o_out.value         = r_q[r_head].value;
    assign o_out.fifo_empty    = r_q[r_head].fifo_empty;
    assign o_out.modifier_bits = r_q[r_head].modifier_bits;
    assign o_out.last          = r_q[r_head].last;

endmodule
